// File: hw/rtl/tblt_pkg.sv
// ----------------------------------------------------------------------------
// Translated block lookup table package
// Shared types and constants for the controller and datapath of the table.
// ----------------------------------------------------------------------------
package tblt_pkg;

  localparam int HANDLE_W   = 6;
  localparam int CNT_W      = 32;
  localparam int INV_W      = 8;
  localparam int BUCKET_LSB = 2;
  localparam int REGION_LSB = 26;
  localparam logic [2:0] RAM_REGION = 3'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_INUSE  = 2'd1;
  localparam logic [1:0] STATUS_UNUSED = 2'd2;

  typedef enum logic [1:0] {
    KIND_REG, KIND_UNREG, KIND_LOOKUP, KIND_PWRITE
  } kind_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE,
    S_RG_RD, S_RG_CHK, S_RG_WR,
    S_UN_RD, S_UN_G, S_UN_DROP,
    S_LK_G, S_LK_GS, S_LK_GC, S_LK_RD, S_LK_CHK,
    S_PW_RD, S_PW_CHK, S_PW_DROP, S_PW_END, S_PW_PG
  } state_t;

  typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_INC, IDX_HANDLE, IDX_GUESS} idx_op_t;
  typedef enum logic [1:0] {SW_NONE, SW_NEW, SW_BUMP} slot_wr_t;
  typedef enum logic [1:0] {GR_NONE, GR_ADDR, GR_SLOT} guess_rd_t;
  typedef enum logic [1:0] {GW_NONE, GW_TAKE, GW_DROP} guess_wr_t;
  typedef enum logic [1:0] {PR_NONE, PR_SPAN, PR_WRITE} page_rd_t;
  typedef enum logic [1:0] {STEP_HOLD, STEP_ZERO, STEP_INC} step_op_t;
  typedef enum logic [1:0] {GC_HOLD, GC_ZERO, GC_LOAD} gcount_op_t;
  typedef enum logic [1:0] {VO_NONE, VO_SET, VO_CLR} valid_op_t;
  typedef enum logic [2:0] {
    EM_NONE, EM_OK, EM_INUSE, EM_UNUSED, EM_MISS, EM_FAST, EM_SLOW, EM_PEND_LAST
  } emit_t;

  typedef struct packed {
    logic       load;
    logic       clear_wr;
    idx_op_t    idx_op;
    logic       slot_rd;
    slot_wr_t   slot_wr;
    guess_rd_t  guess_rd;
    guess_wr_t  guess_wr;
    page_rd_t   page_rd;
    logic       page_wr;
    step_op_t   step_op;
    logic       mark_set;
    gcount_op_t gcount_op;
    valid_op_t  valid_op;
    logic       pend_push;
    emit_t      emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  hnd_ok;
    logic  hnd_valid;
    logic  region;
    logic  outside;
    logic  idx_valid;
    logic  idx_last;
    logic  span_more;
    logic  guess_ok;
    logic  slot_match;
    logic  pw_hit;
    logic  pend_valid;
    logic  clr_done;
  } stat_t;

endpackage

// File: hw/rtl/translated_block_lookup_table.sv
// ----------------------------------------------------------------------------
// Translated block lookup table
// Registers, unregisters and looks up translated code blocks and traps writes
// to RAM pages that hold them.
// ----------------------------------------------------------------------------
// A transaction is taken at a clock edge with start high and busy low. Each
// result is shown for one cycle with strobe high and last marks the final one;
// busy falls as the final result goes out, except after a page write that
// suspended a block, which then updates the page memory. The receiver cannot
// stall. The user writes manual_threshold (thr) with cfg_we and cfg_wdata
// only while busy is low; the block itself does not enforce it. One slot
// memory read port sets the scan speed. Status errors and writes outside
// RAM are answered from the decode. A register outside the RAM region writes
// its slot at once, else it first reads the page memory for each spanned RAM
// page. An unregister reads the slot, then its bucket guess. A lookup tries
// the bucket guess first, then scans the slots, reading each valid one. A
// page write scans every slot, with results spread over the scan.
// After reset the bucket guess and page memories are cleared one entry a
// cycle; busy stays high until both are cleared. PAGE_BYTES, RAM_PAGES and
// HASH_BUCKETS must be powers of two; the block itself does not check this.
// ----------------------------------------------------------------------------
module translated_block_lookup_table import tblt_pkg::*; #(
  parameter int BLOCK_SLOTS    = 64,
  parameter int HASH_BUCKETS   = 1024,
  parameter int RAM_PAGES      = 4096,
  parameter int PAGE_BYTES     = 4096,
  parameter int MAX_SPAN_PAGES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind,
  input  logic [31:0]         address,
  input  logic [31:0]         end_address,
  input  logic [1:0]          mode,
  input  logic [HANDLE_W-1:0] handle,
  input  logic                cfg_we,
  input  logic [INV_W-1:0]    cfg_wdata,
  output logic                strobe,
  output logic [1:0]          status,
  output logic                found,
  output logic                fast_hit,
  output logic [HANDLE_W-1:0] result_handle,
  output logic                last
);

  cmd_t  cmd;
  stat_t st;

  tblt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  tblt_dp #(
    .BLOCK_SLOTS    (BLOCK_SLOTS),
    .HASH_BUCKETS   (HASH_BUCKETS),
    .RAM_PAGES      (RAM_PAGES),
    .PAGE_BYTES     (PAGE_BYTES),
    .MAX_SPAN_PAGES (MAX_SPAN_PAGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .kind          (kind),
    .address       (address),
    .end_address   (end_address),
    .mode          (mode),
    .handle        (handle),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .strobe        (strobe),
    .status        (status),
    .found         (found),
    .fast_hit      (fast_hit),
    .result_handle (result_handle),
    .last          (last)
  );

endmodule

// File: hw/rtl/tblt_ctrl.sv
// ----------------------------------------------------------------------------
// Translated block lookup table controller
// Sequences each transaction and the clearing pass after reset.
// ----------------------------------------------------------------------------
module tblt_ctrl import tblt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.kind)
          KIND_REG: begin
            if (!st.hnd_ok) begin
              cmd.emit = EM_UNUSED;
              state_next = S_IDLE;
            end else if (st.hnd_valid) begin
              cmd.emit = EM_INUSE;
              state_next = S_IDLE;
            end else begin
              cmd.idx_op = IDX_HANDLE;
              cmd.step_op = STEP_ZERO;
              state_next = st.region ? S_RG_RD : S_RG_WR;
            end
          end
          KIND_UNREG: begin
            if (!st.hnd_ok || !st.hnd_valid) begin
              cmd.emit = EM_UNUSED;
              state_next = S_IDLE;
            end else begin
              cmd.idx_op = IDX_HANDLE;
              state_next = S_UN_RD;
            end
          end
          KIND_LOOKUP: begin
            cmd.guess_rd = GR_ADDR;
            state_next = S_LK_G;
          end
          KIND_PWRITE: begin
            if (st.outside) begin
              cmd.emit = EM_MISS;
              state_next = S_IDLE;
            end else begin
              cmd.idx_op = IDX_ZERO;
              state_next = S_PW_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RG_RD: begin
        if (st.span_more) begin
          cmd.page_rd = PR_SPAN;
          state_next = S_RG_CHK;
        end else begin
          state_next = S_RG_WR;
        end
      end
      S_RG_CHK: begin
        cmd.mark_set = 1'b1;
        cmd.step_op = STEP_INC;
        state_next = S_RG_RD;
      end
      S_RG_WR: begin
        cmd.slot_wr = SW_NEW;
        cmd.valid_op = VO_SET;
        cmd.emit = EM_OK;
        state_next = S_IDLE;
      end
      S_UN_RD: begin
        cmd.slot_rd = 1'b1;
        state_next = S_UN_G;
      end
      S_UN_G: begin
        cmd.guess_rd = GR_SLOT;
        state_next = S_UN_DROP;
      end
      S_UN_DROP: begin
        cmd.guess_wr = GW_DROP;
        cmd.valid_op = VO_CLR;
        cmd.emit = EM_OK;
        state_next = S_IDLE;
      end
      S_LK_G: begin
        if (st.guess_ok) begin
          cmd.idx_op = IDX_GUESS;
          state_next = S_LK_GS;
        end else begin
          cmd.gcount_op = GC_ZERO;
          cmd.idx_op = IDX_ZERO;
          state_next = S_LK_RD;
        end
      end
      S_LK_GS: begin
        cmd.slot_rd = 1'b1;
        state_next = S_LK_GC;
      end
      S_LK_GC: begin
        if (st.slot_match) begin
          cmd.slot_wr = SW_BUMP;
          cmd.emit = EM_FAST;
          state_next = S_IDLE;
        end else begin
          cmd.gcount_op = GC_LOAD;
          cmd.idx_op = IDX_ZERO;
          state_next = S_LK_RD;
        end
      end
      S_LK_RD: begin
        if (st.idx_valid) begin
          cmd.slot_rd = 1'b1;
          state_next = S_LK_CHK;
        end else if (st.idx_last) begin
          cmd.emit = EM_MISS;
          state_next = S_IDLE;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_LK_CHK: begin
        if (st.slot_match) begin
          cmd.slot_wr = SW_BUMP;
          cmd.guess_wr = GW_TAKE;
          cmd.emit = EM_SLOW;
          state_next = S_IDLE;
        end else if (st.idx_last) begin
          cmd.emit = EM_MISS;
          state_next = S_IDLE;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_LK_RD;
        end
      end
      S_PW_RD: begin
        if (st.idx_valid) begin
          cmd.slot_rd = 1'b1;
          state_next = S_PW_CHK;
        end else if (st.idx_last) begin
          state_next = S_PW_END;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_PW_CHK: begin
        if (st.pw_hit) begin
          cmd.guess_rd = GR_SLOT;
          state_next = S_PW_DROP;
        end else if (st.idx_last) begin
          state_next = S_PW_END;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_PW_RD;
        end
      end
      S_PW_DROP: begin
        cmd.guess_wr = GW_DROP;
        cmd.valid_op = VO_CLR;
        cmd.pend_push = 1'b1;
        if (st.idx_last) begin
          state_next = S_PW_END;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_PW_RD;
        end
      end
      S_PW_END: begin
        if (st.pend_valid) begin
          cmd.emit = EM_PEND_LAST;
          cmd.page_rd = PR_WRITE;
          state_next = S_PW_PG;
        end else begin
          cmd.emit = EM_MISS;
          state_next = S_IDLE;
        end
      end
      S_PW_PG: begin
        cmd.page_wr = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/tblt_dp.sv
// ----------------------------------------------------------------------------
// Translated block lookup table datapath
// Slot, bucket guess and page memories, scan counters and result registers.
// ----------------------------------------------------------------------------
module tblt_dp import tblt_pkg::*; #(
  parameter int BLOCK_SLOTS    = 64,
  parameter int HASH_BUCKETS   = 1024,
  parameter int RAM_PAGES      = 4096,
  parameter int PAGE_BYTES     = 4096,
  parameter int MAX_SPAN_PAGES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               st,
  input  logic [1:0]          kind,
  input  logic [31:0]         address,
  input  logic [31:0]         end_address,
  input  logic [1:0]          mode,
  input  logic [HANDLE_W-1:0] handle,
  input  logic                cfg_we,
  input  logic [INV_W-1:0]    cfg_wdata,
  output logic                strobe,
  output logic [1:0]          status,
  output logic                found,
  output logic                fast_hit,
  output logic [HANDLE_W-1:0] result_handle,
  output logic                last
);

  localparam int SW    = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int HBW   = $clog2(HASH_BUCKETS);
  localparam int PW    = $clog2(RAM_PAGES);
  localparam int OB    = $clog2(PAGE_BYTES);
  localparam int RB    = PW + OB;
  localparam int MW    = MAX_SPAN_PAGES;
  localparam int STW   = $clog2(MAX_SPAN_PAGES + 1);
  localparam int SUMW  = PW + STW;
  localparam int GW    = HANDLE_W + 1;
  localparam int CLR_N = (HASH_BUCKETS > RAM_PAGES) ? HASH_BUCKETS : RAM_PAGES;
  localparam int CLRW  = $clog2(CLR_N);

  typedef struct packed {
    logic [31:0]      start;
    logic [1:0]       mode;
    logic [PW-1:0]    first_page;
    logic [MW-1:0]    marks;
    logic [CNT_W-1:0] count;
  } slot_t;

  slot_t               slot_mem [BLOCK_SLOTS];
  logic [GW-1:0]       guess_mem [HASH_BUCKETS];
  logic [INV_W:0]      page_mem [RAM_PAGES];

  kind_t               in_kind;
  logic [31:0]         in_addr;
  logic [31:0]         in_end;
  logic [1:0]          in_mode;
  logic [HANDLE_W-1:0] in_handle;
  logic [INV_W-1:0]    thr;

  slot_t               slot_q;
  logic [GW-1:0]       guess_q;
  logic [INV_W:0]      page_q;

  logic [BLOCK_SLOTS-1:0] valid;
  logic [SW-1:0]       idx;
  logic [STW-1:0]      step;
  logic [MW-1:0]       marks;
  logic [CNT_W-1:0]    gcount;
  logic                pend_valid;
  logic [SW-1:0]       pend;
  logic [CLRW-1:0]     clr;

  logic [PW-1:0]       in_page;
  logic [PW-1:0]       end_page;
  logic [HBW-1:0]      in_bucket;
  logic [HBW-1:0]      slot_bucket;
  logic [SUMW-1:0]     span_page;
  logic [CNT_W-1:0]    cnt_inc;
  logic [PW-1:0]       page_dist;
  logic [INV_W-1:0]    inv_next;
  logic                guess_own;

  logic                strobe_next;
  logic [1:0]          status_next;
  logic                found_next;
  logic                fast_hit_next;
  logic [HANDLE_W-1:0] result_handle_next;
  logic                last_next;

  assign in_page     = in_addr[OB +: PW];
  assign end_page    = in_end[OB +: PW];
  assign in_bucket   = in_addr[BUCKET_LSB +: HBW];
  assign slot_bucket = slot_q.start[BUCKET_LSB +: HBW];
  assign span_page   = SUMW'(in_page) + SUMW'(step);
  assign cnt_inc     = (&slot_q.count) ? slot_q.count : slot_q.count + CNT_W'(1);
  assign page_dist   = in_page - slot_q.first_page;
  assign inv_next    = (&page_q[INV_W-1:0]) ? page_q[INV_W-1:0]
                                            : page_q[INV_W-1:0] + INV_W'(1);
  assign guess_own   = guess_q[HANDLE_W] && (guess_q[HANDLE_W-1:0] == HANDLE_W'(idx));

  always_comb begin
    st.kind       = in_kind;
    st.hnd_ok     = {1'b0, in_handle} < (HANDLE_W + 1)'(BLOCK_SLOTS);
    st.hnd_valid  = st.hnd_ok && valid[in_handle[SW-1:0]];
    st.region     = in_addr[REGION_LSB +: 3] == RAM_REGION;
    st.outside    = (33'(in_addr) >> RB) != 33'd0;
    st.idx_valid  = valid[idx];
    st.idx_last   = idx == SW'(BLOCK_SLOTS - 1);
    st.span_more  = ({1'b0, step} < (STW + 1)'(MAX_SPAN_PAGES)) &&
                    (span_page <= SUMW'(end_page));
    st.guess_ok   = guess_q[HANDLE_W] &&
                    ({1'b0, guess_q[HANDLE_W-1:0]} < (HANDLE_W + 1)'(BLOCK_SLOTS)) &&
                    valid[guess_q[SW-1:0]];
    st.slot_match = (slot_q.start == in_addr) && (slot_q.mode == in_mode);
    st.pw_hit     = (in_page >= slot_q.first_page) &&
                    (|(slot_q.marks & (MW'(1) << page_dist)));
    st.pend_valid = pend_valid;
    st.clr_done   = clr == CLRW'(CLR_N - 1);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      thr        <= INV_W'(1);
      clr        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      if (cmd.clear_wr && !st.clr_done) clr <= clr + CLRW'(1);
      case (cmd.valid_op)
        VO_SET:  valid[idx] <= 1'b1;
        VO_CLR:  valid[idx] <= 1'b0;
        default: ;
      endcase
      if (cmd.load) begin
        pend_valid <= 1'b0;
      end else if (cmd.pend_push) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Transaction fields, scan position and running values.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_kind   <= kind_t'(kind);
      in_addr   <= address;
      in_end    <= end_address;
      in_mode   <= mode;
      in_handle <= handle;
    end
    if (cmd.pend_push) pend <= idx;
    case (cmd.idx_op)
      IDX_ZERO:   idx <= '0;
      IDX_INC:    idx <= idx + SW'(1);
      IDX_HANDLE: idx <= in_handle[SW-1:0];
      IDX_GUESS:  idx <= guess_q[SW-1:0];
      default:    ;
    endcase
    case (cmd.step_op)
      STEP_ZERO: begin
        step  <= '0;
        marks <= '0;
      end
      STEP_INC: step <= step + STW'(1);
      default:  ;
    endcase
    if (cmd.mark_set && !page_q[INV_W]) marks <= marks | (MW'(1) << step);
    case (cmd.gcount_op)
      GC_ZERO: gcount <= '0;
      GC_LOAD: gcount <= slot_q.count;
      default: ;
    endcase
  end

  // Slot memory.
  always_ff @(posedge clk) begin
    if (cmd.slot_rd) slot_q <= slot_mem[idx];
    case (cmd.slot_wr)
      SW_NEW:  slot_mem[idx] <= '{start: in_addr, mode: in_mode, first_page: in_page,
                                  marks: marks, count: '0};
      SW_BUMP: slot_mem[idx] <= '{start: slot_q.start, mode: slot_q.mode,
                                  first_page: slot_q.first_page, marks: slot_q.marks,
                                  count: cnt_inc};
      default: ;
    endcase
  end

  // Bucket guess memory.
  always_ff @(posedge clk) begin
    case (cmd.guess_rd)
      GR_ADDR: guess_q <= guess_mem[in_bucket];
      GR_SLOT: guess_q <= guess_mem[slot_bucket];
      default: ;
    endcase
    if (cmd.clear_wr && ({1'b0, clr} < (CLRW + 1)'(HASH_BUCKETS))) begin
      guess_mem[HBW'(clr)] <= '0;
    end else if (cmd.guess_wr == GW_TAKE && gcount <= cnt_inc) begin
      guess_mem[in_bucket] <= {1'b1, HANDLE_W'(idx)};
    end else if (cmd.guess_wr == GW_DROP && guess_own) begin
      guess_mem[slot_bucket] <= '0;
    end
  end

  // Page memory: manual-check flag above the invalidate count.
  always_ff @(posedge clk) begin
    case (cmd.page_rd)
      PR_SPAN:  page_q <= page_mem[PW'(span_page)];
      PR_WRITE: page_q <= page_mem[in_page];
      default:  ;
    endcase
    if (cmd.clear_wr && ({1'b0, clr} < (CLRW + 1)'(RAM_PAGES))) begin
      page_mem[PW'(clr)] <= '0;
    end else if (cmd.page_wr) begin
      page_mem[in_page] <= {page_q[INV_W] | (inv_next >= thr), inv_next};
    end
  end

  // Result values. A suspended handle is held back one step so that the
  // final one of a page write can carry the last flag.
  always_comb begin
    strobe_next        = 1'b1;
    status_next        = STATUS_OK;
    found_next         = 1'b0;
    fast_hit_next      = 1'b0;
    result_handle_next = '0;
    last_next          = 1'b1;
    case (cmd.emit)
      EM_NONE: begin
        strobe_next = cmd.pend_push && pend_valid;
        if (cmd.pend_push && pend_valid) begin
          found_next         = 1'b1;
          result_handle_next = HANDLE_W'(pend);
          last_next          = 1'b0;
        end
      end
      EM_INUSE:  status_next = STATUS_INUSE;
      EM_UNUSED: status_next = STATUS_UNUSED;
      EM_FAST: begin
        found_next         = 1'b1;
        fast_hit_next      = 1'b1;
        result_handle_next = HANDLE_W'(idx);
      end
      EM_SLOW: begin
        found_next         = 1'b1;
        result_handle_next = HANDLE_W'(idx);
      end
      EM_PEND_LAST: begin
        found_next         = 1'b1;
        result_handle_next = HANDLE_W'(pend);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
      if (strobe_next) begin
        status        <= status_next;
        found         <= found_next;
        fast_hit      <= fast_hit_next;
        result_handle <= result_handle_next;
        last          <= last_next;
      end
    end
  end

endmodule
